// File: rtl/vrt_pkg.sv
// Package for the voxel ray walker: widths, register indexes, FSM states and
// the command/status structs that join the controller and the datapath.
// No dependencies.
package vrt_pkg;

  localparam int MAX_CELLS     = 16;
  localparam int COORD_W       = 32;
  localparam int DIR_W         = 16;
  localparam int VS_W          = 24;
  localparam int CELL_W        = 5;
  localparam int IDX_W         = 4;
  localparam int SEG_W         = 31;
  localparam int DIST_W        = 48;
  localparam int DIV_W         = 40;
  localparam int DIR_FRAC_BITS = 15;
  localparam int MAX_RESULTS   = 46;
  localparam int CNT_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [CNT_W-1:0]  LAST_SLOT = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOXEL_SIZE,
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_CELLS_X,
    CFG_CELLS_Y,
    CFG_CELLS_Z
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_INDEX,
    PH_SPACING,
    PH_BOUNDARY
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       emit_flag;
    logic       div_start;
    logic       div_store;
    logic       load_max;
    logic       walk_step;
    logic [1:0] axis;
    phase_t     phase;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic len_pos;
    logic outside;
    logic dir_zero;
    logic div_done;
    logic out_free;
    logic walk_last;
  } status_t;

  // Zero counts as one cell, anything above the map size as the map size.
  function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] c);
    logic [CELL_W-1:0] r;
    r = c;
    if (c == '0) r = CELL_W'(1);
    else if (c > CELL_W'(MAX_CELLS)) r = CELL_W'(MAX_CELLS);
    return r;
  endfunction

endpackage

// File: rtl/vrt_if.sv
// Channel interfaces of the voxel ray walker: ray words in, segment words out.
// Depends on vrt_pkg.
interface vrt_ray_if import vrt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;
  logic signed [DIR_W-1:0]   dir_x;
  logic signed [DIR_W-1:0]   dir_y;
  logic signed [DIR_W-1:0]   dir_z;
  logic signed [COORD_W-1:0] ray_length;

  modport source(output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                 ray_length, input ready);
  modport sink(input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
               ray_length, output ready);
endinterface

interface vrt_seg_if import vrt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segment_length;
  logic [IDX_W-1:0] voxel_x;
  logic [IDX_W-1:0] voxel_y;
  logic [IDX_W-1:0] voxel_z;
  logic             start_outside;
  logic             last_of_ray;

  modport source(output valid, segment_length, voxel_x, voxel_y, voxel_z,
                 start_outside, last_of_ray, input ready);
  modport sink(input valid, segment_length, voxel_x, voxel_y, voxel_z,
               start_outside, last_of_ray, output ready);
endinterface

// File: rtl/vrt_div.sv
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per division,
// done pulses on the cycle after the last bit. Depends on vrt_pkg.
module vrt_div import vrt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [VS_W-1:0]  divisor,
  output logic             done,
  output logic [DIV_W-1:0] quo,
  output logic [VS_W-1:0]  rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [VS_W-1:0]      r_r, r_nxt;
  logic [VS_W-1:0]      dv_r, dv_nxt;
  logic [VS_W:0]        trial;
  logic                 fits;

  // Shift one dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial    = {r_r, q_r[DIV_W-1]};
    fits     = trial >= {1'b0, dv_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    dv_nxt   = dv_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      r_nxt    = '0;
      dv_nxt   = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIV_W-2:0], fits};
      r_nxt   = fits ? VS_W'(trial - {1'b0, dv_r}) : trial[VS_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    r_r  <= r_nxt;
    dv_r <= dv_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

// File: rtl/vrt_ctrl.sv
// Controller of the voxel ray walker: sequences range check, per-axis
// divisions and the voxel walk. Depends on vrt_pkg.
module vrt_ctrl import vrt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready
);

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  phase_t     phase_r, phase_nxt;
  logic       adv;

  // Advance the setup cursor after a store or a saturated load
  always_comb begin
    adv = 1'b0;
    case (state_r)
      ST_DIV_START: adv = (phase_r != PH_INDEX) && status.dir_zero;
      ST_DIV_WAIT:  adv = status.div_done;
      default:      adv = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (status.in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.len_pos) begin
          state_nxt = ST_IDLE;
        end else if (status.outside) begin
          if (status.out_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV_START;
          axis_nxt  = 2'd0;
          phase_nxt = PH_INDEX;
        end
      end
      ST_DIV_START: begin
        if (!adv) state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_WALK: begin
        if (status.out_free && status.walk_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) begin
      if (phase_r == PH_BOUNDARY) begin
        phase_nxt = PH_INDEX;
        if (axis_r == 2'd2) begin
          state_nxt = ST_WALK;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_DIV_START;
        end
      end else begin
        phase_nxt = (phase_r == PH_INDEX) ? PH_SPACING : PH_BOUNDARY;
        state_nxt = ST_DIV_START;
      end
    end
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.phase = phase_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = status.in_valid;
      end
      ST_CHECK: begin
        cmd.emit_flag = status.len_pos && status.outside && status.out_free;
      end
      ST_DIV_START: begin
        cmd.load_max  = adv;
        cmd.div_start = !adv;
      end
      ST_DIV_WAIT: begin
        cmd.div_store = status.div_done;
      end
      ST_WALK: begin
        cmd.walk_step = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
      phase_r <= PH_INDEX;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/vrt_dp.sv
// Datapath of the voxel ray walker: configuration registers, ray registers,
// per-axis walk state, the shared divider and the output word register.
// Depends on vrt_pkg, vrt_if and vrt_div.
module vrt_dp import vrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vrt_ray_if.sink               in_ray,
  vrt_seg_if.source             out_seg,
  input  cmd_t                  cmd,
  output status_t               status
);

  // Configuration
  logic [VS_W-1:0]    vs_cfg_r;
  logic [COORD_W-1:0] org_r   [3];
  logic [CELL_W-1:0]  cells_r [3];
  logic [VS_W-1:0]    vs;
  logic [CELL_W-1:0]  cells   [3];

  // Ray and walk state
  logic [COORD_W:0]   d_r     [3];
  logic [DIR_W-1:0]   dir_r   [3];
  logic [COORD_W-1:0] len_r;
  logic [CELL_W-1:0]  cur_r   [3];
  logic [VS_W-1:0]    rem_r   [3];
  logic [DIST_W-1:0]  nbd_r   [3];
  logic [DIST_W-1:0]  spc_r   [3];
  logic               pos_r   [3];
  logic               neg_r   [3];
  logic [DIST_W-1:0]  cov_r;
  logic [CNT_W-1:0]   cnt_r;

  // Output word
  logic               ov_r, ov_nxt;
  logic [SEG_W-1:0]   o_seg_r;
  logic [IDX_W-1:0]   o_vx_r, o_vy_r, o_vz_r;
  logic               o_out_r, o_last_r;

  // Divider
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [VS_W-1:0]    div_rem;
  logic [DIV_W-1:0]   div_dividend;
  logic [VS_W-1:0]    div_divisor;
  logic [DIR_W-1:0]   ad;
  logic               sel_pos;
  logic [VS_W-1:0]    num24;

  // Walk step
  logic [1:0]         sel;
  logic [DIST_W-1:0]  near_dist, lim48, upto;
  logic [CELL_W-1:0]  edge_idx;
  logic               at_edge, last;
  logic [DIST_W:0]    nsum;
  logic [DIST_W-1:0]  nsat;
  logic               outside;
  logic [COORD_W:0]   d_in    [3];
  logic [COORD_W-1:0] st_in   [3];
  logic [DIR_W-1:0]   dir_in  [3];

  assign vs = (vs_cfg_r == '0) ? VS_W'(1) : vs_cfg_r;

  assign st_in[0]  = in_ray.start_x;
  assign st_in[1]  = in_ray.start_y;
  assign st_in[2]  = in_ray.start_z;
  assign dir_in[0] = in_ray.dir_x;
  assign dir_in[1] = in_ray.dir_y;
  assign dir_in[2] = in_ray.dir_z;

  // Start offset from the map corner and per-axis range check
  always_comb begin
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      cells[a] = clamp_cells(cells_r[a]);
      d_in[a]  = {st_in[a][COORD_W-1], st_in[a]} - {org_r[a][COORD_W-1], org_r[a]};
      if (d_r[a][COORD_W] ||
          (d_r[a][COORD_W-1:0] >= COORD_W'(cells[a]) * COORD_W'(vs)))
        outside = 1'b1;
    end
  end

  // Divider operands for the current axis and phase
  always_comb begin
    ad      = dir_r[cmd.axis][DIR_W-1] ? DIR_W'(-dir_r[cmd.axis]) : dir_r[cmd.axis];
    sel_pos = !dir_r[cmd.axis][DIR_W-1];
    num24   = sel_pos ? VS_W'(vs - rem_r[cmd.axis]) : rem_r[cmd.axis];
    case (cmd.phase)
      PH_INDEX: begin
        div_dividend = DIV_W'(d_r[cmd.axis][COORD_W-1:0]);
        div_divisor  = vs;
      end
      PH_SPACING: begin
        div_dividend = DIV_W'({vs, {DIR_FRAC_BITS{1'b0}}});
        div_divisor  = VS_W'(ad);
      end
      PH_BOUNDARY: begin
        div_dividend = DIV_W'({num24, {DIR_FRAC_BITS{1'b0}}});
        div_divisor  = VS_W'(ad);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = vs;
      end
    endcase
  end

  vrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Pick the nearest boundary, ties to the lower axis, and form one segment
  always_comb begin
    sel = 2'd0;
    if (nbd_r[1] < nbd_r[0]) sel = 2'd1;
    if (nbd_r[2] < nbd_r[sel]) sel = 2'd2;
    near_dist = nbd_r[sel];
    lim48     = DIST_W'(len_r);
    upto      = (near_dist < lim48) ? near_dist : lim48;
    edge_idx  = pos_r[sel] ? CELL_W'(cells[sel] - CELL_W'(1)) : '0;
    at_edge   = cur_r[sel] == edge_idx;
    last      = at_edge || (near_dist >= lim48);
    nsum      = {1'b0, near_dist} + {1'b0, spc_r[sel]};
    nsat      = nsum[DIST_W] ? DIST_MAX : nsum[DIST_W-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_cfg_r <= VS_W'(65536);
      for (int a = 0; a < 3; a++) begin
        org_r[a]   <= '0;
        cells_r[a] <= CELL_W'(MAX_CELLS);
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VOXEL_SIZE: vs_cfg_r   <= cfg_data[VS_W-1:0];
        CFG_ORIGIN_X:   org_r[0]   <= cfg_data;
        CFG_ORIGIN_Y:   org_r[1]   <= cfg_data;
        CFG_ORIGIN_Z:   org_r[2]   <= cfg_data;
        CFG_CELLS_X:    cells_r[0] <= cfg_data[CELL_W-1:0];
        CFG_CELLS_Y:    cells_r[1] <= cfg_data[CELL_W-1:0];
        CFG_CELLS_Z:    cells_r[2] <= cfg_data[CELL_W-1:0];
        default:        vs_cfg_r   <= vs_cfg_r;
      endcase
    end
  end

  // Ray capture, setup stores and walk updates
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int a = 0; a < 3; a++) begin
        d_r[a]   <= d_in[a];
        dir_r[a] <= dir_in[a];
      end
      len_r <= in_ray.ray_length;
      cov_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_store) begin
      case (cmd.phase)
        PH_INDEX: begin
          cur_r[cmd.axis] <= div_quo[CELL_W-1:0];
          rem_r[cmd.axis] <= div_rem;
        end
        PH_SPACING:  spc_r[cmd.axis] <= DIST_W'(div_quo);
        PH_BOUNDARY: begin
          nbd_r[cmd.axis] <= DIST_W'(div_quo);
          pos_r[cmd.axis] <= sel_pos;
          neg_r[cmd.axis] <= !sel_pos;
        end
        default: cur_r[cmd.axis] <= cur_r[cmd.axis];
      endcase
    end
    if (cmd.load_max) begin
      spc_r[cmd.axis] <= DIST_MAX;
      nbd_r[cmd.axis] <= DIST_MAX;
      pos_r[cmd.axis] <= 1'b0;
      neg_r[cmd.axis] <= 1'b0;
    end
    if (cmd.walk_step) begin
      cov_r <= near_dist;
      cnt_r <= cnt_r + CNT_W'(1);
      if (!last) begin
        if (pos_r[sel]) cur_r[sel] <= cur_r[sel] + CELL_W'(1);
        else if (neg_r[sel]) cur_r[sel] <= cur_r[sel] - CELL_W'(1);
        nbd_r[sel] <= nsat;
      end
    end
  end

  // Output word register: load on emit, drop when taken
  always_comb begin
    ov_nxt = ov_r;
    if (cmd.emit_flag || cmd.walk_step) ov_nxt = 1'b1;
    else if (out_seg.ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_flag) begin
      o_seg_r  <= '0;
      o_vx_r   <= '0;
      o_vy_r   <= '0;
      o_vz_r   <= '0;
      o_out_r  <= 1'b1;
      o_last_r <= 1'b1;
    end else if (cmd.walk_step) begin
      o_seg_r  <= SEG_W'(upto - cov_r);
      o_vx_r   <= cur_r[0][IDX_W-1:0];
      o_vy_r   <= cur_r[1][IDX_W-1:0];
      o_vz_r   <= cur_r[2][IDX_W-1:0];
      o_out_r  <= 1'b0;
      o_last_r <= last;
    end
  end

  assign out_seg.valid          = ov_r;
  assign out_seg.segment_length = o_seg_r;
  assign out_seg.voxel_x        = o_vx_r;
  assign out_seg.voxel_y        = o_vy_r;
  assign out_seg.voxel_z        = o_vz_r;
  assign out_seg.start_outside  = o_out_r;
  assign out_seg.last_of_ray    = o_last_r;

  assign status.in_valid  = in_ray.valid;
  assign status.len_pos   = !len_r[COORD_W-1] && (len_r != '0);
  assign status.outside   = outside;
  assign status.dir_zero  = dir_r[cmd.axis] == '0;
  assign status.div_done  = div_done;
  assign status.out_free  = !ov_r || out_seg.ready;
  assign status.walk_last = last || (cnt_r == LAST_SLOT);

endmodule

// File: rtl/voxel_ray_traversal_top.sv
// Voxel ray walker: each ray word yields one segment word per visited voxel
// (indices and distance inside it), or one flagged word if the start lies
// outside the map, or nothing for a length of zero or less. Setup is an accept
// step and a range check, then nine divisions on one shared restoring divider;
// each zero direction component swaps two divisions for two loads of the
// saturated maximum. The walk then issues one word per cycle while the output
// is taken, up to 46; a stalled output stalls the walk. A new ray is taken
// once the previous walk has issued its last word.
// Depends on vrt_pkg, vrt_if, vrt_ctrl and vrt_dp.
module voxel_ray_traversal_top import vrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vrt_ray_if.sink               in_ray,
  vrt_seg_if.source             out_seg
);

  cmd_t    cmd;
  status_t status;

  vrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ray.ready)
  );

  vrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ray    (in_ray),
    .out_seg   (out_seg),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: rtl/vrt_chk.sv
// Port-level checks for the voxel ray walker, bound to the top level.
// Depends on vrt_pkg.
module vrt_chk import vrt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SEG_W-1:0] out_seg_len,
  input logic [IDX_W-1:0] out_vx,
  input logic             out_outside,
  input logic             out_last
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seg_len) && $stable(out_vx))
    else $error("output word changed while stalled");

  // Flagged words are final and carry no segment
  a_flag_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> out_last && out_seg_len == '0 && out_vx == '0)
    else $error("malformed start-outside word");

  // Drop ready right after a ray is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

endmodule

bind voxel_ray_traversal_top vrt_chk u_vrt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ray.valid),
  .in_ready    (in_ray.ready),
  .out_valid   (out_seg.valid),
  .out_ready   (out_seg.ready),
  .out_seg_len (out_seg.segment_length),
  .out_vx      (out_seg.voxel_x),
  .out_outside (out_seg.start_outside),
  .out_last    (out_seg.last_of_ray)
);
